/* rtl/core/hrcd_pkg.sv */
// Types, constants and helper functions of the HTTP response completion detector.
package hrcd_pkg;

  localparam int unsigned LengthBitsDefault = 32;
  localparam int unsigned KeyLen = 15;
  localparam int unsigned OutLenBits = 32;

  localparam logic [2:0] TermDone = 3'd4;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;

  typedef enum logic [1:0] {
    VpNone   = 2'd0,
    VpBlank  = 2'd1,
    VpSign   = 2'd2,
    VpDigits = 2'd3
  } value_phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } hrcd_in_t;

  typedef struct packed {
    logic                  complete;
    logic                  header_done;
    logic                  length_found;
    logic [OutLenBits-1:0] body_length;
  } hrcd_out_t;

  // Characters of "content-length:", indexed from the first one.
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h63; // c
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h6C; // l
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      4'd14:   ch = 8'h3A; // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    if (c >= ChUpA && c <= ChUpZ) begin
      r = c + 8'd32;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

/* rtl/core/hrcd_stream_if.sv */
// Valid/ready stream channel that carries one payload item per handshake.
interface hrcd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/http_response_completion_detector.sv */
// HTTP/1.1 response completion detector with Content-Length framing.
// A result is registered from the input register when the output can advance.
// Throughput: one item per cycle unless out_o stalls; each byte's state update
// is combinational between the input register and the result register.
// Reset: rst_ni clears all parse state and both valid flags asynchronously.
module http_response_completion_detector import hrcd_pkg::*; #(
  parameter int unsigned LengthBits = LengthBitsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  hrcd_stream_if.sink     in_i,
  hrcd_stream_if.source   out_o
);

  localparam int unsigned WideBits = LengthBits + 4;

  logic      in_valid_q;
  hrcd_in_t  in_q;
  logic      out_valid_q;
  hrcd_out_t out_q;
  hrcd_out_t out_d;
  logic      advance;
  logic      step;

  logic [2:0]            term_q, term_d;
  logic [3:0]            key_q, key_d;
  value_phase_e          phase_q, phase_d;
  logic                  key_seen_q, key_seen_d;
  logic                  minus_q, minus_d;
  logic [LengthBits-1:0] plen_q, plen_d;
  logic                  hdr_q, hdr_d;
  logic [LengthBits-1:0] body_q, body_d;
  logic                  done_q, done_d;

  assign advance     = !out_valid_q || out_o.ready;
  assign step        = in_valid_q && advance;
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

  always_comb begin
    logic [7:0]            c;
    logic [7:0]            lc;
    logic                  is_digit;
    logic [WideBits-1:0]   ext;
    logic [WideBits-1:0]   sum;
    logic [LengthBits-1:0] shown;
    logic [63:0]           shown_wide;

    c        = in_q.data_byte;
    lc       = to_lower(c);
    is_digit = (c >= ChZero) && (c <= ChNine);

    term_d     = term_q;
    key_d      = key_q;
    phase_d    = phase_q;
    key_seen_d = key_seen_q;
    minus_d    = minus_q;
    plen_d     = plen_q;
    hdr_d      = hdr_q;
    body_d     = body_q;
    done_d     = done_q;

    if (in_q.first_byte) begin
      term_d     = '0;
      key_d      = '0;
      phase_d    = VpNone;
      key_seen_d = 1'b0;
      minus_d    = 1'b0;
      plen_d     = '0;
      hdr_d      = 1'b0;
      body_d     = '0;
      done_d     = 1'b0;
    end

    // Next length if this byte is a digit, saturating at the all-ones value.
    ext = WideBits'(plen_d);
    sum = (ext << 3) + (ext << 1) + WideBits'(c - ChZero);

    if (!done_d) begin
      if (!hdr_d) begin
        if (phase_d != VpNone) begin
          if (phase_d == VpBlank && (c == ChSpace || c == ChTab)) begin
            phase_d = VpBlank;
          end else if (phase_d == VpBlank && c == ChPlus) begin
            phase_d = VpSign;
          end else if (phase_d == VpBlank && c == ChMinus) begin
            minus_d = 1'b1;
            phase_d = VpSign;
          end else if (is_digit) begin
            if (sum[WideBits-1:LengthBits] != '0) begin
              plen_d = '1;
            end else begin
              plen_d = sum[LengthBits-1:0];
            end
            phase_d = VpDigits;
          end else begin
            phase_d = VpNone;
          end
        end else if (!key_seen_d) begin
          if (key_d < 4'(KeyLen) && lc == key_char(key_d)) begin
            key_d = key_d + 4'd1;
          end else if (lc == key_char(4'd0)) begin
            key_d = 4'd1;
          end else begin
            key_d = 4'd0;
          end
          if (key_d >= 4'(KeyLen)) begin
            key_seen_d = 1'b1;
            phase_d    = VpBlank;
          end
        end

        if (c == ChCr) begin
          term_d = (term_d == 3'd2) ? 3'd3 : 3'd1;
        end else if (c == ChLf) begin
          if (term_d == 3'd1) begin
            term_d = 3'd2;
          end else if (term_d == 3'd3) begin
            term_d = TermDone;
          end else begin
            term_d = 3'd0;
          end
        end else begin
          term_d = 3'd0;
        end

        if (term_d == TermDone) begin
          hdr_d   = 1'b1;
          phase_d = VpNone;
          if (!key_seen_d || minus_d || plen_d == '0) begin
            done_d = 1'b1;
          end
        end
      end else begin
        if (!(&body_d)) begin
          body_d = body_d + LengthBits'(1);
        end
        if (body_d >= plen_d) begin
          done_d = 1'b1;
        end
      end
    end

    shown      = minus_d ? '0 : plen_d;
    shown_wide = 64'(shown);

    out_d.complete     = done_d;
    out_d.header_done  = hdr_d;
    out_d.length_found = key_seen_d;
    if (shown_wide > 64'h0000_0000_FFFF_FFFF) begin
      out_d.body_length = '1;
    end else begin
      out_d.body_length = shown_wide[OutLenBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      term_q      <= '0;
      key_q       <= '0;
      phase_q     <= VpNone;
      key_seen_q  <= 1'b0;
      minus_q     <= 1'b0;
      plen_q      <= '0;
      hdr_q       <= 1'b0;
      body_q      <= '0;
      done_q      <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end

      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (step) begin
        term_q     <= term_d;
        key_q      <= key_d;
        phase_q    <= phase_d;
        key_seen_q <= key_seen_d;
        minus_q    <= minus_d;
        plen_q     <= plen_d;
        hdr_q      <= hdr_d;
        body_q     <= body_d;
        done_q     <= done_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.payload;
    end
    if (step) begin
      out_q <= out_d;
    end
  end

endmodule
